/* rtl/sxp_pkg.sv */
// ----------------------------------------------------------------------------
// sxp_pkg
// Shared types and constants of the SysEx chunk to USB-MIDI packet converter.
// ----------------------------------------------------------------------------
package sxp_pkg;

   // Default port geometry
   localparam int unsigned MAX_INTERFACES_DEF = 4;
   localparam int unsigned CABLES_DEF         = 16;

   // SysEx framing bytes
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // Code index number reset values
   localparam logic [3:0] CIN_CONTINUE_RST  = 4'd4;
   localparam logic [3:0] CIN_END_ONE_RST   = 4'd5;
   localparam logic [3:0] CIN_END_TWO_RST   = 4'd6;
   localparam logic [3:0] CIN_END_THREE_RST = 4'd7;

   // Result queue depth (power of two, room for two items)
   localparam int unsigned RSP_FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      CONT_NONE   = 2'd0,
      CONT_START  = 2'd1,
      CONT_END    = 2'd2,
      CONT_MIDDLE = 2'd3
   } cont_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DROPPED   = 3'd1,
      ST_FLAGGED   = 3'd2,
      ST_BAD_PORT  = 3'd3,
      ST_NOT_SYSEX = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_CIN_CONTINUE  = 2'd0,
      CSR_CIN_END_ONE   = 2'd1,
      CSR_CIN_END_TWO   = 2'd2,
      CSR_CIN_END_THREE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_LOOKUP
   } seq_state_type;

   // One carry store entry: up to two pending bytes of a port
   typedef struct packed {
      logic [1:0] len;
      logic [7:0] b1;
      logic [7:0] b0;
   } carry_entry_type;

   typedef struct packed {
      logic [7:0] iface_number;
      logic [7:0] cable;
      cont_type   cont_state;
      logic [7:0] byte_count;
      logic [7:0] data_byte0;
      logic [7:0] data_byte1;
      logic [7:0] data_byte2;
      logic [7:0] data_byte3;
   } req_item_type;

   typedef struct packed {
      logic        packet_valid;
      logic [7:0]  header_byte;
      logic [7:0]  out_byte1;
      logic [7:0]  out_byte2;
      logic [7:0]  out_byte3;
      status_type  status;
      logic        last;
      logic [31:0] malformed_total;
      logic [31:0] converted_total;
   } rsp_beat_type;

   typedef struct packed {
      logic [3:0] cin_continue;
      logic [3:0] cin_end_one;
      logic [3:0] cin_end_two;
      logic [3:0] cin_end_three;
   } cin_cfg_type;

   // Packer to sequencer control
   typedef struct packed {
      logic            two_beats;
      logic            carry_we;
      carry_entry_type carry_new;
      logic [31:0]     malformed_next;
      logic [31:0]     converted_next;
   } pack_ctl_type;

endpackage

/* rtl/sxp_carry_ram.sv */
// ----------------------------------------------------------------------------
// sxp_carry_ram
// Per-port carry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sxp_carry_ram
   import sxp_pkg::*;
#(
   parameter int unsigned DEPTH  = MAX_INTERFACES_DEF * CABLES_DEF,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  carry_entry_type   wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output carry_entry_type   rd_data
);

   carry_entry_type mem_ff [DEPTH];
   carry_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sxp_packer.sv */
// ----------------------------------------------------------------------------
// sxp_packer
// Checks one chunk against its port's carry, re-chunks the bytes into up to
// two event packets and works out the new carry and running counts.
// ----------------------------------------------------------------------------
module sxp_packer
   import sxp_pkg::*;
#(
   parameter int unsigned MAX_INTERFACES = MAX_INTERFACES_DEF,
   parameter int unsigned CABLES         = CABLES_DEF
) (
   input  req_item_type    item,
   input  carry_entry_type carry,
   input  cin_cfg_type     cfg,
   input  logic [31:0]     malformed_cnt,
   input  logic [31:0]     converted_cnt,
   output rsp_beat_type    beat0,
   output rsp_beat_type    beat1,
   output pack_ctl_type    ctl
);

   logic [7:0] d [4];
   logic [7:0] len;
   logic [7:0] cat_bytes [6];
   logic [1:0] eff_len;
   logic [1:0] last_idx;
   logic [2:0] total;
   logic [2:0] rem;
   logic [7:0] hdr_hi;
   logic       bad_port;
   logic       sysex_led;
   logic       whole;
   logic       is_start;
   logic       is_end;
   logic       flag;
   logic       bad_whole;
   logic       bad_len;
   status_type status_val;
   logic [1:0] mal_inc;
   logic [1:0] conv_inc;
   rsp_beat_type b0_c;
   rsp_beat_type b1_c;

   // Packet beat with unused payload bytes zeroed
   function automatic rsp_beat_type make_beat(input logic       valid,
                                              input logic [7:0] hdr,
                                              input logic [7:0] p0,
                                              input logic [7:0] p1,
                                              input logic [7:0] p2,
                                              input logic [2:0] n,
                                              input status_type st);
      rsp_beat_type beat;
      beat              = '0;
      beat.packet_valid = valid;
      beat.header_byte  = hdr;
      beat.out_byte1    = (n > 3'd0) ? p0 : 8'h00;
      beat.out_byte2    = (n > 3'd1) ? p1 : 8'h00;
      beat.out_byte3    = (n > 3'd2) ? p2 : 8'h00;
      beat.status       = st;
      return beat;
   endfunction

   // End CIN picked by the trailing byte count
   function automatic logic [3:0] end_cin(input logic [2:0] n, input cin_cfg_type c);
      logic [3:0] cin;
      if (n <= 3'd1) begin
         cin = c.cin_end_one;
      end else if (n == 3'd2) begin
         cin = c.cin_end_two;
      end else begin
         cin = c.cin_end_three;
      end
      return cin;
   endfunction

   assign d[0] = item.data_byte0;
   assign d[1] = item.data_byte1;
   assign d[2] = item.data_byte2;
   assign d[3] = item.data_byte3;
   assign len  = item.byte_count;

   // Checks
   assign bad_port  = (item.iface_number == 8'd0)
                   || (item.iface_number > 8'(MAX_INTERFACES))
                   || (item.cable >= 8'(CABLES));
   assign sysex_led = (len != 8'd0) && (d[0] == SYSEX_START);
   assign whole     = (item.cont_state == CONT_NONE);
   assign is_start  = (item.cont_state == CONT_START) || whole;
   assign is_end    = (item.cont_state == CONT_END) || whole;
   assign flag      = is_start && ((carry.len != 2'd0) || (len == 8'd0)
                                   || (d[0] != SYSEX_START));
   assign last_idx  = len[1:0] - 2'd1;
   assign bad_whole = whole && ((len < 8'd2) || (len > 8'd4) || (d[last_idx] != SYSEX_END));
   assign bad_len   = (len == 8'd0) || (len > 8'd4);
   assign status_val = flag ? ST_FLAGGED : ST_OK;
   assign hdr_hi    = {item.cable[3:0], 4'h0};

   // Carry bytes followed by chunk bytes; a flagged start drops the carry
   assign eff_len = (flag || (carry.len == 2'd3)) ? 2'd0 : carry.len;
   assign total   = 3'(eff_len) + len[2:0];
   assign rem     = total - 3'd3;

   always_comb begin
      case (eff_len)
         2'd1: begin
            cat_bytes = '{carry.b0, d[0], d[1], d[2], d[3], 8'h00};
         end
         2'd2: begin
            cat_bytes = '{carry.b0, carry.b1, d[0], d[1], d[2], d[3]};
         end
         default: begin
            cat_bytes = '{d[0], d[1], d[2], d[3], 8'h00, 8'h00};
         end
      endcase
   end

   // Packet assembly, carry update and running counts
   always_comb begin
      b0_c          = make_beat(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ST_OK);
      b1_c          = '0;
      ctl.two_beats = 1'b0;
      ctl.carry_we  = 1'b0;
      ctl.carry_new = '0;
      mal_inc       = 2'd0;
      conv_inc      = 2'd0;
      if (bad_port) begin
         mal_inc     = 2'd1;
         b0_c.status = ST_BAD_PORT;
      end else if (whole && !sysex_led) begin
         if ((len == 8'd0) || (len > 8'd3)) begin
            mal_inc     = 2'd1;
            b0_c.status = ST_DROPPED;
         end else begin
            b0_c.status = ST_NOT_SYSEX;
         end
      end else if (bad_whole || bad_len) begin
         mal_inc      = {1'b0, flag} + 2'd1;
         ctl.carry_we = flag;
         b0_c.status  = ST_DROPPED;
      end else begin
         mal_inc      = {1'b0, flag};
         ctl.carry_we = 1'b1;
         if (is_end) begin
            if (total > 3'd3) begin
               b0_c = make_beat(1'b1, hdr_hi | {4'h0, cfg.cin_continue},
                                cat_bytes[0], cat_bytes[1], cat_bytes[2], 3'd3, status_val);
               b1_c = make_beat(1'b1, hdr_hi | {4'h0, end_cin(rem, cfg)},
                                cat_bytes[3], cat_bytes[4], cat_bytes[5], rem, status_val);
               ctl.two_beats = 1'b1;
               conv_inc      = 2'd2;
            end else begin
               b0_c = make_beat(1'b1, hdr_hi | {4'h0, end_cin(total, cfg)},
                                cat_bytes[0], cat_bytes[1], cat_bytes[2], total, status_val);
               conv_inc = 2'd1;
            end
         end else begin
            if (total == 3'd6) begin
               b0_c = make_beat(1'b1, hdr_hi | {4'h0, cfg.cin_continue},
                                cat_bytes[0], cat_bytes[1], cat_bytes[2], 3'd3, status_val);
               b1_c = make_beat(1'b1, hdr_hi | {4'h0, cfg.cin_continue},
                                cat_bytes[3], cat_bytes[4], cat_bytes[5], 3'd3, status_val);
               ctl.two_beats = 1'b1;
               conv_inc      = 2'd2;
            end else if (total >= 3'd3) begin
               b0_c = make_beat(1'b1, hdr_hi | {4'h0, cfg.cin_continue},
                                cat_bytes[0], cat_bytes[1], cat_bytes[2], 3'd3, status_val);
               conv_inc          = 2'd1;
               ctl.carry_new.len = rem[1:0];
               ctl.carry_new.b0  = cat_bytes[3];
               ctl.carry_new.b1  = cat_bytes[4];
            end else begin
               // chunk only fills the carry
               b0_c.status       = status_val;
               ctl.carry_new.len = total[1:0];
               ctl.carry_new.b0  = cat_bytes[0];
               ctl.carry_new.b1  = cat_bytes[1];
            end
         end
      end
      ctl.malformed_next = malformed_cnt + 32'(mal_inc);
      ctl.converted_next = converted_cnt + 32'(conv_inc);
   end

   // Beat totals: malformed settles before any beat, converted per packet
   always_comb begin
      beat0                = b0_c;
      beat0.last           = !ctl.two_beats;
      beat0.malformed_total = ctl.malformed_next;
      beat0.converted_total = converted_cnt + 32'(b0_c.packet_valid);
      beat1                = b1_c;
      beat1.last           = 1'b1;
      beat1.malformed_total = ctl.malformed_next;
      beat1.converted_total = ctl.converted_next;
   end

endmodule

/* rtl/sxp_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// sxp_rsp_fifo
// Result queue: takes one or two beats per item, hands out one beat a cycle while head_ready is high.
// ----------------------------------------------------------------------------
module sxp_rsp_fifo
   import sxp_pkg::*;
#(
   parameter int unsigned DEPTH = RSP_FIFO_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         push_two,
   input  rsp_beat_type beat0,
   input  rsp_beat_type beat1,
   output logic         room_two,
   output logic         head_valid,
   input  logic         head_ready,
   output rsp_beat_type head
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_beat_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] push_n;
   logic             pop;

   assign pop        = head_valid && head_ready;
   assign push_n     = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0);
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   assign count_in   = count_ff + push_n - CNT_W'(pop);
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign room_two   = (count_ff <= CNT_W'(DEPTH - 2));

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Beat storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= beat0;
         if (push_two) begin
            entries_ff[wr_ptr_ff + PTR_W'(1)] <= beat1;
         end
      end
   end

endmodule

/* rtl/sysex_chunk_to_usb_midi_packets.sv */
// ----------------------------------------------------------------------------
// sysex_chunk_to_usb_midi_packets
// Re-chunks SysEx chunks into USB-MIDI 1.0 event packets through a per-port
// carry held in a synchronous memory.
// ----------------------------------------------------------------------------
//  Channel  Dir  Width                Contents
//  req_     in   tdata 56, tuser 2    one SysEx chunk for an interface and cable
//  rsp_     out  tdata 96, tuser 4    one or two result beats per chunk, tlast
//  csr_     in   index 2, data 4      code index number registers
//
//  An item goes through accept (carry memory read issued), then lookup
//  (packets built, carry written back). Each item leaves 1 or 2 beats; the
//  result port moves one beat a cycle while rsp_tready is high.
//  After reset a clearing pass over all MAX_INTERFACES * CABLES ports (64 by
//  default) zeroes the carry store; no chunk is taken meanwhile.
//  req_tready drops while a lookup runs or the result queue lacks room for two
//  beats; a stalled rsp_ side holds its beat.
// ----------------------------------------------------------------------------
module sysex_chunk_to_usb_midi_packets
   import sxp_pkg::*;
#(
   parameter int unsigned MAX_INTERFACES = MAX_INTERFACES_DEF,
   parameter int unsigned CABLES         = CABLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // iface_number, cable, byte_count, data_byte0..data_byte3
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // cont_state
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // header_byte, out_byte1, out_byte2, out_byte3, malformed_total, converted_total
   output logic [95:0] rsp_tdata,
   // packet_valid, status
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int unsigned NPORTS = MAX_INTERFACES * CABLES;
   localparam int unsigned PORT_W = (NPORTS > 1) ? $clog2(NPORTS) : 1;

   seq_state_type   state_ff, state_in;
   logic [PORT_W-1:0] clr_ff, clr_in;
   logic [PORT_W-1:0] port_ff;
   logic [PORT_W-1:0] req_port;
   logic [12:0]     port_full;
   req_item_type    req_item;
   req_item_type    item_ff;
   cin_cfg_type     cfg_ff;
   logic [31:0]     malformed_ff;
   logic [31:0]     converted_ff;
   logic            req_accept;
   logic            clear_done;
   logic            room_two;
   logic            push;
   logic            ram_we;
   logic [PORT_W-1:0] ram_waddr;
   carry_entry_type ram_wdata;
   carry_entry_type carry_rd;
   rsp_beat_type    beat0;
   rsp_beat_type    beat1;
   rsp_beat_type    head;
   pack_ctl_type    ctl;

   // Unpack the chunk beat
   assign req_item.iface_number = req_tdata[7:0];
   assign req_item.cable        = req_tdata[15:8];
   assign req_item.cont_state   = cont_type'(req_tuser);
   assign req_item.byte_count   = req_tdata[23:16];
   assign req_item.data_byte0   = req_tdata[31:24];
   assign req_item.data_byte1   = req_tdata[39:32];
   assign req_item.data_byte2   = req_tdata[47:40];
   assign req_item.data_byte3   = req_tdata[55:48];

   assign req_accept = req_tvalid && req_tready;

   // Port index; only meaningful for a valid interface and cable
   assign port_full = (13'(req_item.iface_number) - 13'd1) * 13'(CABLES)
                    + 13'(req_item.cable);
   assign req_port  = port_full[PORT_W-1:0];

   assign clear_done = (clr_ff == PORT_W'(NPORTS - 1));

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_CLEAR:  if (clear_done) state_in = SEQ_IDLE;
         SEQ_IDLE:   if (req_accept) state_in = SEQ_LOOKUP;
         SEQ_LOOKUP: state_in = SEQ_IDLE;
         default:    state_in = SEQ_CLEAR;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      push       = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = port_ff;
      ram_wdata  = ctl.carry_new;
      clr_in     = clr_ff;
      unique case (state_ff)
         SEQ_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + PORT_W'(1);
         end
         SEQ_IDLE: begin
            req_tready = room_two;
         end
         SEQ_LOOKUP: begin
            push   = 1'b1;
            ram_we = ctl.carry_we;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         clr_ff       <= '0;
         malformed_ff <= '0;
         converted_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (push) begin
            malformed_ff <= ctl.malformed_next;
            converted_ff <= ctl.converted_next;
         end
      end
   end

   // Item held for the lookup cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
         port_ff <= req_port;
      end
   end

   // Code index number registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cin_continue  <= CIN_CONTINUE_RST;
         cfg_ff.cin_end_one   <= CIN_END_ONE_RST;
         cfg_ff.cin_end_two   <= CIN_END_TWO_RST;
         cfg_ff.cin_end_three <= CIN_END_THREE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CIN_CONTINUE:  cfg_ff.cin_continue  <= csr_wdata;
            CSR_CIN_END_ONE:   cfg_ff.cin_end_one   <= csr_wdata;
            CSR_CIN_END_TWO:   cfg_ff.cin_end_two   <= csr_wdata;
            CSR_CIN_END_THREE: cfg_ff.cin_end_three <= csr_wdata;
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Carry store: read on accept, written back in the lookup cycle. The next
   // read comes no earlier than the cycle after the write, so no forwarding.
   sxp_carry_ram #(
      .DEPTH  (NPORTS),
      .ADDR_W (PORT_W)
   ) u_carry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_port),
      .rd_data (carry_rd)
   );

   sxp_packer #(
      .MAX_INTERFACES (MAX_INTERFACES),
      .CABLES         (CABLES)
   ) u_packer (
      .item          (item_ff),
      .carry         (carry_rd),
      .cfg           (cfg_ff),
      .malformed_cnt (malformed_ff),
      .converted_cnt (converted_ff),
      .beat0         (beat0),
      .beat1         (beat1),
      .ctl           (ctl)
   );

   sxp_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_two   (ctl.two_beats),
      .beat0      (beat0),
      .beat1      (beat1),
      .room_two   (room_two),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head       (head)
   );

   // Pack the result beat
   assign rsp_tdata = {head.converted_total, head.malformed_total, head.out_byte3,
                       head.out_byte2, head.out_byte1, head.header_byte};
   assign rsp_tuser = {head.status, head.packet_valid};
   assign rsp_tlast = head.last;

endmodule

/* rtl/sxp_checker.sv */
// ----------------------------------------------------------------------------
// sxp_checker
// Port-level checks of the SysEx packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module sxp_checker
   import sxp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Reset starts the clearing pass with nothing to send
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("chunk taken or beat shown right after reset");

   // One chunk in flight: no accept in the lookup cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("chunk accepted during lookup");

   // Stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // A beat without a packet is the only one of its item and carries no bytes
   a_lone_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[31:0] == 32'd0))
      else $error("empty result beat not lone or not zero");

   // Dropped, bad port and non-SysEx results never carry a packet
   a_error_no_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser[3:1] == ST_DROPPED) || (rsp_tuser[3:1] == ST_BAD_PORT)
                     || (rsp_tuser[3:1] == ST_NOT_SYSEX)) |-> !rsp_tuser[0])
      else $error("packet sent with an error status");

endmodule

bind sysex_chunk_to_usb_midi_packets sxp_checker u_sxp_checker (.*);

/* dv/sxp_packet_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_packet_checker
// Watches the chunk, packet and register ports of the SysEx packetiser. It
// predicts the USB-MIDI beats of every accepted chunk from its own copy of
// the per-port carry, the counters and the CIN registers, and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sxp_packet_checker
   import sxp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int unsigned pending,
   output int unsigned fail_count
);

   localparam int unsigned PORTS        = MAX_INTERFACES_DEF * CABLES_DEF;
   localparam int unsigned REPORT_LIMIT = 10;

   cin_cfg_type  cins;
   logic [1:0]   carry_len [PORTS];
   logic [7:0]   carry_b0  [PORTS];
   logic [7:0]   carry_b1  [PORTS];
   logic [31:0]  malformed_cnt;
   logic [31:0]  converted_cnt;
   rsp_beat_type expected_packets [$];
   int unsigned  mismatches = 0;

   // Beat that carries no packet, only a status
   function automatic rsp_beat_type lone_beat(input status_type st);
      rsp_beat_type b;
      b                 = '0;
      b.status          = st;
      b.malformed_total = malformed_cnt;
      b.converted_total = converted_cnt;
      return b;
   endfunction

   // Event packet beat with cnt payload bytes, unused ones zero
   function automatic rsp_beat_type packet_beat(input logic [7:0] cab, input logic [3:0] cin,
                                                input logic [7:0] p0, input logic [7:0] p1,
                                                input logic [7:0] p2, input int unsigned cnt,
                                                input status_type st);
      rsp_beat_type b;
      b                 = '0;
      b.packet_valid    = 1'b1;
      b.header_byte     = {cab[3:0], cin};
      b.out_byte1       = p0;
      b.out_byte2       = (cnt >= 2) ? p1 : 8'h00;
      b.out_byte3       = (cnt >= 3) ? p2 : 8'h00;
      b.status          = st;
      b.malformed_total = malformed_cnt;
      b.converted_total = converted_cnt;
      return b;
   endfunction

   // Works out the beats of one chunk and queues them
   task automatic predict_packets(input req_item_type it);
      rsp_beat_type beats [2];
      logic [7:0]   d [4];
      logic [7:0]   pend [8];
      int unsigned  port, total, pos, rem, n, k;
      logic         whole, is_start, is_end, flagged;
      status_type   st;
      logic [3:0]   cin;
      d[0]    = it.data_byte0;
      d[1]    = it.data_byte1;
      d[2]    = it.data_byte2;
      d[3]    = it.data_byte3;
      n       = 0;
      flagged = 1'b0;
      for (k = 0; k < 8; k++) pend[k] = 8'h00;

      if (it.iface_number < 1 || it.iface_number > MAX_INTERFACES_DEF ||
          it.cable >= CABLES_DEF) begin
         malformed_cnt++;
         beats[0] = lone_beat(ST_BAD_PORT);
         n        = 1;
      end else if (it.cont_state == CONT_NONE &&
                   !(it.byte_count >= 1 && d[0] == SYSEX_START)) begin
         // plain MIDI is not converted here; odd lengths count as malformed
         if (it.byte_count < 1 || it.byte_count > 3) begin
            malformed_cnt++;
            beats[0] = lone_beat(ST_DROPPED);
         end else begin
            beats[0] = lone_beat(ST_NOT_SYSEX);
         end
         n = 1;
      end else begin
         port     = (it.iface_number - 1) * CABLES_DEF + it.cable;
         whole    = (it.cont_state == CONT_NONE);
         is_start = (it.cont_state == CONT_START) || whole;
         is_end   = (it.cont_state == CONT_END) || whole;

         // start with a leftover carry or without F0: flag, clear, go on
         if (is_start && (carry_len[port] != 0 || it.byte_count == 0 ||
                          d[0] != SYSEX_START)) begin
            malformed_cnt++;
            carry_len[port] = 2'd0;
            flagged         = 1'b1;
         end

         if (whole && (it.byte_count < 2 || it.byte_count > 4 ||
                       d[(it.byte_count - 1) & 3] != SYSEX_END)) begin
            malformed_cnt++;
            beats[0] = lone_beat(ST_DROPPED);
            n        = 1;
         end else if (it.byte_count == 0 || it.byte_count > 4) begin
            malformed_cnt++;
            beats[0] = lone_beat(ST_DROPPED);
            n        = 1;
         end else begin
            // carry bytes first, then the chunk
            total = 0;
            for (k = 0; k < carry_len[port]; k++) begin
               pend[total] = (k == 0) ? carry_b0[port] : carry_b1[port];
               total++;
            end
            for (k = 0; k < it.byte_count; k++) begin
               pend[total] = d[k];
               total++;
            end
            carry_len[port] = 2'd0;
            st  = flagged ? ST_FLAGGED : ST_OK;
            pos = 0;
            if (is_end) begin
               while (total - pos > 3) begin
                  converted_cnt++;
                  beats[n] = packet_beat(it.cable, cins.cin_continue, pend[pos],
                                         pend[pos + 1], pend[pos + 2], 3, st);
                  n++;
                  pos += 3;
               end
               rem = total - pos;
               cin = (rem <= 1) ? cins.cin_end_one :
                     (rem == 2) ? cins.cin_end_two : cins.cin_end_three;
               converted_cnt++;
               beats[n] = packet_beat(it.cable, cin, pend[pos], pend[pos + 1],
                                      pend[pos + 2], rem, st);
               n++;
            end else begin
               while (total - pos >= 3) begin
                  converted_cnt++;
                  beats[n] = packet_beat(it.cable, cins.cin_continue, pend[pos],
                                         pend[pos + 1], pend[pos + 2], 3, st);
                  n++;
                  pos += 3;
               end
               // what is left waits for the next chunk of this port
               carry_len[port] = 2'(total - pos);
               carry_b0[port]  = pend[pos];
               carry_b1[port]  = pend[pos + 1];
               if (n == 0) begin
                  beats[0] = lone_beat(st);
                  n        = 1;
               end
            end
         end
      end

      beats[n - 1].last = 1'b1;
      for (k = 0; k < n; k++) expected_packets.push_back(beats[k]);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         if (mismatches < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_beat(input rsp_beat_type got);
      rsp_beat_type want;
      if (expected_packets.size() == 0) begin
         if (mismatches < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected, header %0h",
                     $time, got.header_byte);
         mismatches++;
         return;
      end
      want = expected_packets.pop_front();
      compare_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
      compare_field("header_byte", 32'(want.header_byte), 32'(got.header_byte));
      compare_field("out_byte1", 32'(want.out_byte1), 32'(got.out_byte1));
      compare_field("out_byte2", 32'(want.out_byte2), 32'(got.out_byte2));
      compare_field("out_byte3", 32'(want.out_byte3), 32'(got.out_byte3));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last", 32'(want.last), 32'(got.last));
      compare_field("malformed_total", want.malformed_total, got.malformed_total);
      compare_field("converted_total", want.converted_total, got.converted_total);
   endtask

   // Sample all ports at the clock edge
   always @(posedge clock) begin
      rsp_beat_type got;
      req_item_type it;
      if (reset) begin
         for (int i = 0; i < PORTS; i++) carry_len[i] = 2'd0;
         malformed_cnt = '0;
         converted_cnt = '0;
         cins = {CIN_CONTINUE_RST, CIN_END_ONE_RST, CIN_END_TWO_RST, CIN_END_THREE_RST};
         expected_packets.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CIN_CONTINUE:  cins.cin_continue  = csr_wdata;
               CSR_CIN_END_ONE:   cins.cin_end_one   = csr_wdata;
               CSR_CIN_END_TWO:   cins.cin_end_two   = csr_wdata;
               CSR_CIN_END_THREE: cins.cin_end_three = csr_wdata;
               default: ;
            endcase
         end
         // older beats are checked before the new chunk is predicted
         if (rsp_tvalid && rsp_tready) begin
            got                 = '0;
            got.packet_valid    = rsp_tuser[0];
            got.status          = status_type'(rsp_tuser[3:1]);
            got.header_byte     = rsp_tdata[7:0];
            got.out_byte1       = rsp_tdata[15:8];
            got.out_byte2       = rsp_tdata[23:16];
            got.out_byte3       = rsp_tdata[31:24];
            got.malformed_total = rsp_tdata[63:32];
            got.converted_total = rsp_tdata[95:64];
            got.last            = rsp_tlast;
            check_beat(got);
         end
         if (req_tvalid && req_tready) begin
            it.iface_number = req_tdata[7:0];
            it.cable        = req_tdata[15:8];
            it.byte_count   = req_tdata[23:16];
            it.data_byte0   = req_tdata[31:24];
            it.data_byte1   = req_tdata[39:32];
            it.data_byte2   = req_tdata[47:40];
            it.data_byte3   = req_tdata[55:48];
            it.cont_state   = cont_type'(req_tuser);
            predict_packets(it);
         end
      end
      pending    <= expected_packets.size();
      fail_count <= mismatches;
   end

endmodule

/* dv/sysex_chunk_to_usb_midi_packets_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_chunk_to_usb_midi_packets_test
// Drives SysEx chunks into the packetiser: a directed set over bad ports,
// plain MIDI, whole messages, flagged starts and length errors, then random
// SysEx runs mixed with malformed noise under several CIN settings, with
// random idling on both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module sysex_chunk_to_usb_midi_packets_test;
   import sxp_pkg::*;

   localparam int unsigned PHASE_ITEMS    = 345;
   localparam int unsigned HOLD_CYCLES    = 320;
   localparam int unsigned STALL_LIMIT    = 3000;
   localparam int unsigned IDLE_PERCENT   = 32;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en  = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [3:0]  csr_wdata  = '0;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned items_sent  = 0;
   int unsigned hold_asked  = 0;
   int unsigned hold_taken  = 0;
   int unsigned hold_left   = 0;
   int unsigned stall_count = 0;
   logic        steady      = 1'b0;

   always #10 clock = ~clock;

   sysex_chunk_to_usb_midi_packets u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sxp_packet_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // Packet sink: random stalls, a counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: too long without any beat moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // One chunk beat; valid stays high afterwards unless a gap follows
   task automatic send_chunk(input logic [7:0] ifc, input logic [7:0] cab,
                             input cont_type ct, input logic [7:0] cnt,
                             input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [7:0] d3);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d3, d2, d1, d0, cnt, cab, ifc};
      req_tuser  <= ct;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_cins(input logic [3:0] c_cont, input logic [3:0] c_one,
                           input logic [3:0] c_two, input logic [3:0] c_three);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CIN_CONTINUE;
      csr_wdata <= c_cont;
      @(posedge clock);
      csr_index <= CSR_CIN_END_ONE;
      csr_wdata <= c_one;
      @(posedge clock);
      csr_index <= CSR_CIN_END_TWO;
      csr_wdata <= c_two;
      @(posedge clock);
      csr_index <= CSR_CIN_END_THREE;
      csr_wdata <= c_three;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly 7-bit SysEx payload, now and then a full byte
   function automatic logic [7:0] payload_byte();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
   endfunction

   // A SysEx message on one port: whole, or start, middles and end
   task automatic send_sysex_run(input bit truncate);
      logic [7:0]  ifc, cab, cnt;
      logic [7:0]  d [4];
      int unsigned mids, k;
      ifc = 8'($urandom_range(1, MAX_INTERFACES_DEF));
      cab = 8'($urandom_range(CABLES_DEF - 1));
      for (k = 0; k < 4; k++) d[k] = payload_byte();
      if ($urandom_range(3) == 0) begin
         cnt        = 8'($urandom_range(2, 4));
         d[0]       = SYSEX_START;
         d[cnt - 1] = SYSEX_END;
         send_chunk(ifc, cab, CONT_NONE, cnt, d[0], d[1], d[2], d[3]);
      end else begin
         cnt  = 8'($urandom_range(1, 4));
         d[0] = SYSEX_START;
         send_chunk(ifc, cab, CONT_START, cnt, d[0], d[1], d[2], d[3]);
         mids = $urandom_range(4);
         repeat (mids) begin
            for (k = 0; k < 4; k++) d[k] = payload_byte();
            send_chunk(ifc, cab, CONT_MIDDLE, 8'($urandom_range(1, 4)),
                       d[0], d[1], d[2], d[3]);
         end
         if (!truncate) begin
            for (k = 0; k < 4; k++) d[k] = payload_byte();
            cnt        = 8'($urandom_range(1, 4));
            d[cnt - 1] = SYSEX_END;
            send_chunk(ifc, cab, CONT_END, cnt, d[0], d[1], d[2], d[3]);
         end
      end
   endtask

   // Random fields over their whole range, biased towards the edges
   task automatic send_noise();
      logic [7:0]  ifc, cab, cnt;
      logic [7:0]  d [4];
      int unsigned k;
      ifc = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      cab = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
      cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      for (k = 0; k < 4; k++) d[k] = 8'($urandom_range(255));
      if ($urandom_range(1) == 1) d[0] = SYSEX_START;
      if (cnt >= 1 && cnt <= 4 && $urandom_range(1) == 1) d[cnt - 1] = SYSEX_END;
      send_chunk(ifc, cab, cont_type'($urandom_range(3)), cnt, d[0], d[1], d[2], d[3]);
   endtask

   task automatic run_traffic(input int unsigned phase_no);
      int unsigned first, pick;
      bit          hooked;
      first  = items_sent;
      hooked = 1'b0;
      while (items_sent - first < PHASE_ITEMS) begin
         // halfway: receiver hold-off in one phase, full drain in another
         if (!hooked && items_sent - first >= PHASE_ITEMS / 2) begin
            hooked = 1'b1;
            if (phase_no == 1) hold_asked <= hold_asked + 1;
            if (phase_no == 2) wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 70)      send_sysex_run(1'b0);
         else if (pick < 80) send_sysex_run(1'b1);
         else                send_noise();
      end
   endtask

   initial begin
      int unsigned ph;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bad ports
      send_chunk(8'd0, 8'd0, CONT_NONE, 8'd3, SYSEX_START, 8'h01, SYSEX_END, 8'h00);
      send_chunk(8'd5, 8'hFF, CONT_START, 8'd4, SYSEX_START, 8'h01, 8'h02, 8'h03);
      send_chunk(8'd1, 8'd16, CONT_END, 8'd1, SYSEX_END, 8'h00, 8'h00, 8'h00);
      // plain MIDI: passed over, or malformed by its length
      send_chunk(8'd1, 8'd0, CONT_NONE, 8'd2, 8'h90, 8'h40, 8'h00, 8'h00);
      send_chunk(8'd1, 8'd0, CONT_NONE, 8'd0, 8'h12, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd1, 8'd0, CONT_NONE, 8'd4, 8'h80, 8'h40, 8'h7F, 8'hFF);
      // whole messages, good and broken
      send_chunk(8'd1, 8'd1, CONT_NONE, 8'd3, SYSEX_START, 8'h7E, SYSEX_END, 8'h00);
      send_chunk(8'd1, 8'd1, CONT_NONE, 8'd2, SYSEX_START, SYSEX_END, 8'h00, 8'h00);
      send_chunk(8'd2, 8'd3, CONT_NONE, 8'd4, SYSEX_START, 8'h01, 8'h02, SYSEX_END);
      send_chunk(8'd2, 8'd3, CONT_NONE, 8'd4, SYSEX_START, 8'h01, 8'h02, 8'h03);
      send_chunk(8'd2, 8'd3, CONT_NONE, 8'd5, SYSEX_START, 8'h01, 8'h02, SYSEX_END);
      // carry through start, restart over a carry, middles and end
      send_chunk(8'd3, 8'd4, CONT_START, 8'd2, SYSEX_START, 8'h11, 8'h00, 8'h00);
      send_chunk(8'd3, 8'd4, CONT_START, 8'd4, SYSEX_START, 8'h21, 8'h22, 8'h23);
      send_chunk(8'd3, 8'd4, CONT_MIDDLE, 8'd4, 8'h31, 8'h32, 8'h33, 8'h34);
      send_chunk(8'd3, 8'd4, CONT_MIDDLE, 8'd1, 8'h41, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd3, 8'd4, CONT_MIDDLE, 8'd1, 8'h51, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd3, 8'd4, CONT_END, 8'd4, 8'h61, 8'h62, 8'h63, SYSEX_END);
      // start without F0, bad lengths
      send_chunk(8'd4, 8'd15, CONT_START, 8'd3, 8'h12, 8'h13, 8'h14, 8'h00);
      send_chunk(8'd4, 8'd15, CONT_END, 8'd0, SYSEX_END, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd4, 8'd15, CONT_START, 8'd0, SYSEX_START, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd4, 8'd15, CONT_MIDDLE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_chunk(8'd4, 8'd14, CONT_END, 8'd1, SYSEX_END, 8'h00, 8'h00, 8'h00);
      send_chunk(8'd4, 8'd15, CONT_NONE, 8'd2, SYSEX_START, SYSEX_END, 8'h00, 8'h00);
      // whole message over a leftover carry is flagged but sent
      send_chunk(8'd1, 8'd2, CONT_START, 8'd4, SYSEX_START, 8'h01, 8'h02, 8'h03);
      send_chunk(8'd1, 8'd2, CONT_NONE, 8'd3, SYSEX_START, 8'h7F, SYSEX_END, 8'h00);

      // random traffic under several CIN settings
      for (ph = 0; ph < 5; ph++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         case (ph)
            0: set_cins(4'hF, 4'hF, 4'hF, 4'hF);
            1: set_cins(4'h0, 4'h0, 4'h0, 4'h0);
            4: set_cins(CIN_CONTINUE_RST, CIN_END_ONE_RST, CIN_END_TWO_RST,
                        CIN_END_THREE_RST);
            default: set_cins(4'($urandom_range(15)), 4'($urandom_range(15)),
                              4'($urandom_range(15)), 4'($urandom_range(15)));
         endcase
         steady <= (ph == 0);
         run_traffic(ph);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
